[rtl/itr_pkg.sv]
// Shared types, constants and digit helpers for the radix digit converter.
package itr_pkg;

	localparam int VALUE_PORT_W = 64;
	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;
	localparam int COUNT_W = 7;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW = 6;
	localparam int DEF_VALUE_WIDTH = 64;
	localparam int DEF_MAX_DIGITS = 64;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
	localparam logic [CHAR_W-1:0] CHAR_A = 7'd65;
	localparam logic [CHAR_W-1:0] CHAR_Z = 7'd90;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_LOAD
	} itr_state_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) r = BASE_MIN;
		if (b > BASE_MAX) r = BASE_MAX;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_LIMIT) c = CHAR_ZERO + {1'b0, d};
		else c = CHAR_A + {1'b0, d} - {1'b0, DECIMAL_LIMIT};
		return c;
	endfunction

endpackage

[rtl/itr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module itr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/integer_to_radix_digits.sv]
// Converts an unsigned integer into ASCII digits of a base from 2 to 36, most significant first.
// The converter takes one item at a time. A bit-serial restoring divider produces each digit and
// writes its remainder into a 64-entry digit RAM. The digits are then read back from the RAM in
// reverse order, each through a RAM read state and then a load into the output register, which
// waits while a held beat is stalled by the consumer. The next item is accepted as soon as the
// last digit of the current one sits in the output register. Bases below 2 are treated as 2 and
// bases above 36 as 36; only the low VALUE_WIDTH bits of value are used, and at most MAX_DIGITS
// of the least significant digits are produced.
module integer_to_radix_digits
	import itr_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [VALUE_PORT_W-1:0] value,
	input  logic [BASE_W-1:0]       base,
	output logic                    digit_valid,
	input  logic                    digit_ready,
	output logic [CHAR_W-1:0]       digit_char,
	output logic [COUNT_W-1:0]      digit_count,
	output logic                    last
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	itr_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] quot_q;
	logic [BASE_W-1:0]      rem_q;
	logic [BASE_W-1:0]      base_q;
	logic [CNT_W-1:0]       div_cnt_q;
	logic [COUNT_W-1:0]     n_q;
	logic [COUNT_W-1:0]     total_q;
	logic [STORE_AW-1:0]    idx_q;

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_last_q;

	// One restoring division step.
	logic [BASE_W:0]        trial;
	logic                   fits;
	logic [BASE_W:0]        rem_next;
	logic [VALUE_WIDTH-1:0] quot_next;
	logic [COUNT_W-1:0]     n_next;
	logic                   last_step;
	logic                   conv_done;

	logic                   accept;
	logic                   ram_we;
	logic                   load_out;
	logic [BASE_W-1:0]      ram_rdata;

	assign trial     = {rem_q, quot_q[VALUE_WIDTH-1]};
	assign fits      = trial >= {1'b0, base_q};
	assign rem_next  = fits ? (trial - {1'b0, base_q}) : trial;
	assign quot_next = {quot_q[VALUE_WIDTH-2:0], fits};
	assign n_next    = n_q + COUNT_W'(1);
	assign last_step = div_cnt_q == CNT_W'(VALUE_WIDTH - 1);
	assign conv_done = (quot_next == '0) || (n_next == COUNT_W'(MAX_DIGITS));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (last_step && conv_done) state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!out_valid_q || digit_ready) begin
					state_d = (idx_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		ram_we     = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_DIV:  ram_we     = last_step;
			ST_RD:   ;
			ST_LOAD: load_out   = !out_valid_q || digit_ready;
			default: ;
		endcase
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			quot_q      <= '0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (digit_ready) out_valid_q <= 1'b0;
			if (accept) quot_q <= value[VALUE_WIDTH-1:0];
			else if (state_q == ST_DIV) quot_q <= quot_next;
			if (ram_we && conv_done) total_q <= n_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q    <= clamp_base(base);
			rem_q     <= '0;
			div_cnt_q <= '0;
			n_q       <= '0;
		end else if (state_q == ST_DIV) begin
			if (last_step) begin
				rem_q     <= '0;
				div_cnt_q <= '0;
				n_q       <= n_next;
				// The newest digit sits at n; emission starts there.
				if (conv_done) idx_q <= n_q[STORE_AW-1:0];
			end else begin
				rem_q     <= rem_next[BASE_W-1:0];
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end
		end
		if (load_out) begin
			out_char_q  <= to_ascii(ram_rdata);
			out_count_q <= total_q;
			out_last_q  <= idx_q == '0;
			if (idx_q != '0) idx_q <= idx_q - STORE_AW'(1);
		end
	end

	itr_ram #(
		.WIDTH(BASE_W),
		.DEPTH(STORE_DEPTH)
	) u_digit_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(n_q[STORE_AW-1:0]),
		.wdata(rem_next[BASE_W-1:0]),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign digit_valid = out_valid_q;
	assign digit_char  = out_char_q;
	assign digit_count = out_count_q;
	assign last        = out_last_q;

endmodule

[rtl/itr_checker.sv]
// Port-level checks for the radix digit converter, bound to its top level.
module itr_checker
	import itr_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_ready,
	input logic [VALUE_PORT_W-1:0] value,
	input logic [BASE_W-1:0]       base,
	input logic                    digit_valid,
	input logic                    digit_ready,
	input logic [CHAR_W-1:0]       digit_char,
	input logic [COUNT_W-1:0]      digit_count,
	input logic                    last
);

	// A stalled output beat must hold its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_ready |=> digit_valid && $stable(digit_char)
			&& $stable(digit_count) && $stable(last))
		else $error("output beat changed while stalled");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE)
			|| (digit_char >= CHAR_A && digit_char <= CHAR_Z))
		else $error("digit character out of range");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> digit_count != '0)
		else $error("digit count is zero");

	// Once an item is taken the converter is busy dividing.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("new item accepted during conversion");

	// A value and a base taken together cannot yield a digit in the next cycle.
	a_no_early_digit: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !digit_valid |=> !digit_valid)
		else $error("digit appeared right after accept");

endmodule

bind integer_to_radix_digits itr_checker u_itr_checker (.*);
